// File: rtl/core/sirs_pkg.sv
// ----------------------------------------------------------------------------
// sirs_pkg: shared types and constants
// Register codes, symbol constants, controller states and status structs.
// ----------------------------------------------------------------------------
package sirs_pkg;

    localparam int unsigned C_MAX_RADIX = 16;

    localparam logic [7:0] C_SYM_MINUS = 8'h2D;
    localparam logic [7:0] C_SYM_PLUS  = 8'h2B;

    localparam logic [1:0] C_REG_RADIX    = 2'd0;
    localparam logic [1:0] C_REG_SYM_LOW  = 2'd1;
    localparam logic [1:0] C_REG_SYM_HIGH = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK_GO,
        S_CHECK_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_POP,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic done;
        logic ok;
    } t_chk_res;

    typedef struct packed {
        logic done;
        logic q_nz;
    } t_div_res;

    typedef struct packed {
        logic rd_vld;
        logic rd_last;
        logic one_left;
    } t_stk_stat;

endpackage

// File: rtl/core/signed_int_to_radix_symbols.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_symbols: signed integer to text in a configured radix
// Writes a signed 32-bit value as symbol bytes, most significant first.
//
// Request: i_value is taken at a rising edge with i_start high and o_busy low.
// Results: o_symbol / o_last on o_valid, one cycle each; a leading '-' for
// negative values, o_last on the final digit. No stall from the receiver.
// Config: i_cfg_we with i_cfg_idx 0 radix, 1 symbols 0..7, 2 symbols 8..15.
// Write only while idle. A radix outside 2..16, or a reserved, zero or
// repeated symbol among those in use, gives no results.
// Sequence: a scan of the 16-entry symbol table, then each digit from the
// 32-step bit-serial divider, then one symbol per cycle popped from the
// digit stack. A '-' is on the ports when the table scan ends, before the
// first digit. A bad table frees the block after the scan; an invalid radix
// leaves it idle.
// Reset: synchronous, active low; config registers clear to zero, block idle.
// ----------------------------------------------------------------------------
module signed_int_to_radix_symbols import sirs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [31:0] i_value,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    output logic               o_valid,
    output logic [7:0]         o_symbol,
    output logic               o_last
);

    t_state      r_state;
    t_state      n_state;
    logic [4:0]  r_radix;
    logic [63:0] r_sym_low;
    logic [63:0] r_sym_high;
    logic [31:0] r_mag;
    logic        r_neg;
    logic        r_valid;
    logic [7:0]  r_symbol;
    logic        r_last;

    logic        n_chk_start;
    logic        n_div_start;
    logic        n_push;
    logic        n_pop;
    logic        n_radix_ok;
    logic        n_accept;
    logic [127:0] n_sym_all;

    t_chk_res    chk_res;
    t_div_res    div_res;
    t_stk_stat   stk_stat;
    logic [31:0] div_quot;
    logic [3:0]  div_rem;
    logic [3:0]  stk_data;

    assign n_sym_all  = {r_sym_high, r_sym_low};
    assign n_radix_ok = (r_radix >= 5'd2) && (r_radix <= 5'(C_MAX_RADIX));
    assign n_accept   = i_start && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= '0;
            r_sym_low  <= '0;
            r_sym_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                C_REG_RADIX:    r_radix    <= i_cfg_data[4:0];
                C_REG_SYM_LOW:  r_sym_low  <= i_cfg_data;
                C_REG_SYM_HIGH: r_sym_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:       if (i_start && n_radix_ok) n_state = S_CHECK_GO;
            S_CHECK_GO:   n_state = S_CHECK_WAIT;
            S_CHECK_WAIT: begin
                if (chk_res.done) n_state = chk_res.ok ? S_DIV_GO : S_IDLE;
            end
            S_DIV_GO:     n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_res.done) n_state = div_res.q_nz ? S_DIV_GO : S_POP;
            end
            S_POP:        if (stk_stat.one_left) n_state = S_FLUSH;
            S_FLUSH:      n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_chk_start = (r_state == S_CHECK_GO);
        n_div_start = (r_state == S_DIV_GO);
        n_push      = (r_state == S_DIV_WAIT) && div_res.done;
        n_pop       = (r_state == S_POP);
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_neg <= i_value[31];
            r_mag <= i_value[31] ? (32'd0 - 32'(i_value)) : 32'(i_value);
        end else if (n_push) begin
            r_mag <= div_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            priority if ((r_state == S_CHECK_WAIT) && chk_res.done && chk_res.ok && r_neg) begin
                r_valid  <= 1'b1;
                r_symbol <= C_SYM_MINUS;
                r_last   <= 1'b0;
            end else if (stk_stat.rd_vld) begin
                r_valid  <= 1'b1;
                r_symbol <= n_sym_all[{stk_data, 3'b000} +: 8];
                r_last   <= stk_stat.rd_last;
            end
        end
    end

    sirs_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (n_chk_start),
        .i_symbols (n_sym_all),
        .i_radix   (r_radix),
        .o_res     (chk_res)
    );

    sirs_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (r_mag),
        .i_radix    (r_radix),
        .o_res      (div_res),
        .o_quotient (div_quot),
        .o_rem      (div_rem)
    );

    sirs_stack u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (n_push),
        .i_push_data (div_rem),
        .i_pop       (n_pop),
        .o_rd_data   (stk_data),
        .o_stat      (stk_stat)
    );

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_symbol = r_symbol;
    assign o_last   = r_valid & r_last;

endmodule

// File: rtl/core/sirs_check.sv
// ----------------------------------------------------------------------------
// sirs_check: symbol table scan
// Rotates a copy of the table one byte per cycle and tests the byte in front
// against reserved codes and against every other symbol in use.
// ----------------------------------------------------------------------------
module sirs_check import sirs_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [127:0]   i_symbols,
    input  logic [4:0]     i_radix,
    output t_chk_res       o_res
);

    logic [15:0][7:0] r_sym;
    logic [3:0]       r_idx;
    logic             r_run;
    logic             r_ok;
    logic             r_done;
    logic             n_bad;

    always_comb begin
        logic       in_i;
        logic [3:0] j;
        in_i  = {1'b0, r_idx} < i_radix;
        n_bad = in_i && (r_sym[0] == 8'h00 || r_sym[0] == C_SYM_MINUS ||
                         r_sym[0] == C_SYM_PLUS);
        for (int k = 1; k < 16; k++) begin
            j = r_idx + 4'(k);
            if (in_i && ({1'b0, j} < i_radix) && r_sym[k] == r_sym[0]) begin
                n_bad = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_ok   <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_ok  <= 1'b1;
                r_idx <= '0;
            end else if (r_run) begin
                r_ok  <= r_ok && !n_bad;
                r_idx <= r_idx + 4'd1;
                if (r_idx == 4'd15) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sym <= i_symbols;
        end else if (r_run) begin
            r_sym <= {r_sym[0], r_sym[15:1]};
        end
    end

    assign o_res.done = r_done;
    assign o_res.ok   = r_ok;

endmodule

// File: rtl/core/sirs_divider.sv
// ----------------------------------------------------------------------------
// sirs_divider: bit-serial divide by radix
// Restoring division of a 32-bit magnitude by the radix, one quotient bit
// per cycle; yields quotient, remainder digit and a quotient-nonzero flag.
// ----------------------------------------------------------------------------
module sirs_divider import sirs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [4:0]  i_radix,
    output t_div_res    o_res,
    output logic [31:0] o_quotient,
    output logic [3:0]  o_rem
);

    logic [31:0] r_q;
    logic [4:0]  r_r;
    logic [4:0]  r_cnt;
    logic        r_run;
    logic        r_done;
    logic        r_nz;
    logic [4:0]  n_t;
    logic        n_ge;

    assign n_t  = {r_r[3:0], r_q[31]};
    assign n_ge = n_t >= i_radix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q  <= i_dividend;
            r_r  <= '0;
            r_nz <= 1'b0;
        end else if (r_run) begin
            r_q  <= {r_q[30:0], n_ge};
            r_r  <= n_ge ? (n_t - i_radix) : n_t;
            r_nz <= r_nz | n_ge;
        end
    end

    assign o_res.done = r_done;
    assign o_res.q_nz = r_nz;
    assign o_quotient = r_q;
    assign o_rem      = r_r[3:0];

endmodule

// File: rtl/core/sirs_stack.sv
// ----------------------------------------------------------------------------
// sirs_stack: digit stack
// Holds remainder digits least significant first and returns them in reverse
// order through a registered read port.
// ----------------------------------------------------------------------------
module sirs_stack import sirs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [3:0]  i_push_data,
    input  logic        i_pop,
    output logic [3:0]  o_rd_data,
    output t_stk_stat   o_stat
);

    logic [3:0] r_mem [32];
    logic [5:0] r_sp;
    logic [5:0] n_sp_dec;
    logic [3:0] r_rd_data;
    logic       r_rd_vld;
    logic       r_rd_last;

    assign n_sp_dec = r_sp - 6'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_rd_vld <= 1'b0;
            if (i_push) begin
                r_sp <= r_sp + 6'd1;
            end else if (i_pop) begin
                r_sp      <= n_sp_dec;
                r_rd_vld  <= 1'b1;
                r_rd_last <= (n_sp_dec == 6'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_sp[4:0]] <= i_push_data;
        end
        r_rd_data <= r_mem[n_sp_dec[4:0]];
    end

    assign o_rd_data       = r_rd_data;
    assign o_stat.rd_vld   = r_rd_vld;
    assign o_stat.rd_last  = r_rd_last;
    assign o_stat.one_left = (r_sp == 6'd1);

endmodule

// File: rtl/core/sirs_checker.sv
// ----------------------------------------------------------------------------
// sirs_checker: port-level checks
// Watches the top-level ports for framing of the symbol stream.
// ----------------------------------------------------------------------------
module sirs_checker import sirs_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic signed [31:0] i_value,
    input logic               i_cfg_we,
    input logic [1:0]         i_cfg_idx,
    input logic [63:0]        i_cfg_data,
    input logic               o_valid,
    input logic [7:0]         o_symbol,
    input logic               o_last
);

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_busy)
        else $error("output active after reset");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_symbol == C_SYM_MINUS) |-> !o_last)
        else $error("sign symbol marked last");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("symbol right after last");

    a_busy_mid_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_busy)
        else $error("idle while value incomplete");

endmodule

bind signed_int_to_radix_symbols sirs_checker u_sirs_checker (.*);

// File: tb/tb_signed_int_to_radix_symbols.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_radix_symbols: self-checking bench for the radix converter
// A directed table walks reset state, radix and value extremes, invalid radix
// settings and broken symbol tables. Random requests then run over many random
// radix and symbol settings, under three sender idle profiles. Every output
// symbol is checked in order against the directed text or a local predictor.
// ----------------------------------------------------------------------------
module tb_signed_int_to_radix_symbols;
    import sirs_pkg::*;

    localparam logic [1:0] C_REG_SPARE = 2'd3;
    localparam logic [63:0] HEX_LO = 64'h3736_3534_3332_3130;
    localparam logic [63:0] HEX_HI = 64'h4645_4443_4241_3938;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } t_sym_res;

    typedef struct {
        bit                 is_cfg;
        logic [1:0]         idx;
        logic [63:0]        data;
        logic signed [31:0] value;
        int                 n_txt;
        logic [263:0]       txt;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic signed [31:0] i_value = '0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = C_REG_RADIX;
    logic [63:0]        i_cfg_data = '0;
    logic               o_busy;
    logic               o_valid;
    logic [7:0]         o_symbol;
    logic               o_last;

    logic [4:0]  cfg_radix = '0;
    logic [63:0] cfg_sym_lo = '0;
    logic [63:0] cfg_sym_hi = '0;

    t_sym_res exp_syms[$];
    t_dir_row dir_tab[$];
    int n_errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_writes = 0;
    int idle_pct = 0;

    signed_int_to_radix_symbols uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_value    (i_value),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_symbol   (o_symbol),
        .o_last     (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] digit_sym(logic [3:0] d);
        logic [63:0] word;
        word = d[3] ? cfg_sym_hi : cfg_sym_lo;
        return word[d[2:0]*8 +: 8];
    endfunction

    function automatic bit table_valid(int r);
        logic [7:0] s;
        for (int i = 0; i < r; i++) begin
            s = digit_sym(4'(i));
            if (s == 8'h00 || s == C_SYM_MINUS || s == C_SYM_PLUS)
                return 1'b0;
            for (int j = i + 1; j < r; j++)
                if (digit_sym(4'(j)) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_symbols(logic [31:0] raw);
        logic [31:0] mag;
        logic [31:0] r;
        logic [3:0]  digs[$];
        t_sym_res    e;
        r = {27'd0, cfg_radix};
        if (r < 2 || r > C_MAX_RADIX || !table_valid(int'(r)))
            return;
        if (raw[31]) begin
            e.symbol = C_SYM_MINUS;
            e.last = 1'b0;
            exp_syms.push_back(e);
            mag = 32'd0 - raw;
        end else begin
            mag = raw;
        end
        do begin
            digs.push_front(4'(mag % r));
            mag = mag / r;
        end while (mag != 0);
        for (int k = 0; k < digs.size(); k++) begin
            e.symbol = digit_sym(digs[k]);
            e.last = (k == digs.size() - 1);
            exp_syms.push_back(e);
        end
    endfunction

    function automatic void add_cfg(logic [1:0] idx, logic [63:0] data);
        t_dir_row row;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        row.value = '0;
        row.n_txt = 0;
        row.txt = '0;
        dir_tab.push_back(row);
    endfunction

    // n < 0: expectation comes from the predictor
    function automatic void add_val(logic signed [31:0] v, int n, logic [263:0] t);
        t_dir_row row;
        row.is_cfg = 1'b0;
        row.idx = C_REG_RADIX;
        row.data = '0;
        row.value = v;
        row.n_txt = n;
        row.txt = t;
        dir_tab.push_back(row);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            C_REG_RADIX: cfg_radix = data[4:0];
            C_REG_SYM_LOW: cfg_sym_lo = data;
            C_REG_SYM_HIGH: cfg_sym_hi = data;
            default: ;
        endcase
        n_writes++;
        @(posedge i_clk);
    endtask

    task automatic send_value(input logic signed [31:0] v, input int n_txt,
                              input logic [263:0] txt, input bit hold);
        t_sym_res e;
        i_start <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_busy);
        if (n_txt < 0) begin
            predict_symbols(v);
        end else begin
            for (int k = 0; k < n_txt; k++) begin
                e.symbol = txt[8*(n_txt-1-k) +: 8];
                e.last = (k == n_txt - 1);
                exp_syms.push_back(e);
            end
        end
        n_items++;
        if (!hold)
            i_start <= 1'b0;
    endtask

    // block must be idle before any register write
    task automatic wait_drained();
        while (exp_syms.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic new_setting();
        logic [7:0]  tbl[16];
        bit          used[256];
        logic [7:0]  b;
        logic [4:0]  r;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] rdata;
        int          pos;
        case ($urandom_range(0, 11))
            0: r = 5'($urandom_range(0, 1));
            1: r = 5'($urandom_range(17, 31));
            default: r = 5'($urandom_range(2, 16));
        endcase
        for (int i = 0; i < 16; i++) begin
            do b = 8'($urandom_range(1, 255));
            while (used[b] || b == C_SYM_MINUS || b == C_SYM_PLUS);
            used[b] = 1'b1;
            tbl[i] = b;
        end
        if ($urandom_range(0, 7) == 0) begin
            pos = (r >= 2 && r <= 16 && $urandom_range(0, 3) != 0) ?
                  $urandom_range(0, r - 1) : $urandom_range(0, 15);
            case ($urandom_range(0, 3))
                0: tbl[pos] = C_SYM_PLUS;
                1: tbl[pos] = C_SYM_MINUS;
                2: tbl[pos] = 8'h00;
                default: tbl[pos] = tbl[(pos + 1 + $urandom_range(0, 14)) % 16];
            endcase
        end
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = tbl[i];
            hi[8*i +: 8] = tbl[8+i];
        end
        rdata = {$urandom, $urandom};
        rdata[4:0] = r;
        if ($urandom_range(0, 1) == 0) begin
            write_reg(C_REG_SYM_HIGH, hi);
            write_reg(C_REG_RADIX, rdata);
            write_reg(C_REG_SYM_LOW, lo);
        end else begin
            write_reg(C_REG_RADIX, rdata);
            write_reg(C_REG_SYM_LOW, lo);
            write_reg(C_REG_SYM_HIGH, hi);
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(C_REG_SPARE, {$urandom, $urandom});
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] p;
        int          r;
        int          n;
        r = (cfg_radix < 2) ? 10 : int'(cfg_radix);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4: return 32'($urandom_range(0, 300));
            5: return -32'($urandom_range(1, 300));
            6: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h1;
                endcase
            end
            7: begin
                p = 32'd1;
                n = $urandom_range(0, 31);
                repeat (n) p = p * r;
                return p + 32'($urandom_range(0, 2)) - 32'd1;
            end
            8: return $urandom | 32'h8000_0000;
            default: return 32'h1 << $urandom_range(0, 31);
        endcase
    endfunction

    always @(posedge i_clk) begin : mon
        t_sym_res e;
        if (i_rst_n && o_valid === 1'b1) begin
            n_results++;
            if (exp_syms.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected symbol, expected none, actual %h last %b",
                         $time, o_symbol, o_last);
            end else begin
                e = exp_syms.pop_front();
                if (o_symbol !== e.symbol) begin
                    n_errors++;
                    $display("%0t: symbol mismatch, expected %h actual %h",
                             $time, e.symbol, o_symbol);
                end
                if (o_last !== e.last) begin
                    n_errors++;
                    $display("%0t: last mismatch, expected %b actual %b",
                             $time, e.last, o_last);
                end
            end
        end
    end

    initial begin
        int  gap;
        bit  hold;

        add_val(32'sd5, 0, '0);
        add_cfg(C_REG_SYM_LOW, HEX_LO);
        add_cfg(C_REG_SYM_HIGH, HEX_HI);
        add_cfg(C_REG_RADIX, 64'd16);
        add_val(32'sd0, 1, "0");
        add_val(32'h7FFF_FFFF, 8, "7FFFFFFF");
        add_val(32'h8000_0000, 9, "-80000000");
        add_val(-32'sd1, 2, "-1");
        add_val(32'h1234_5678, 8, "12345678");
        add_cfg(C_REG_RADIX, 64'd10);
        add_val(32'h8000_0000, 11, "-2147483648");
        add_val(32'h7FFF_FFFF, 10, "2147483647");
        add_val(-32'sd7, 2, "-7");
        add_cfg(C_REG_RADIX, 64'd2);
        add_val(32'h8000_0000, -1, '0);
        add_val(32'h7FFF_FFFF, -1, '0);
        add_val(32'sd6, 3, "110");
        add_cfg(C_REG_RADIX, 64'd1);
        add_val(32'sd3, 0, '0);
        add_cfg(C_REG_RADIX, 64'hFFFF_FFFF_FFFF_FFF1);
        add_val(32'sd3, 0, '0);
        add_cfg(C_REG_RADIX, 64'hFFFF_FFFF_FFFF_FFFF);
        add_val(32'sd3, 0, '0);
        add_cfg(C_REG_RADIX, 64'hFFFF_FFFF_FFFF_FFF0);
        add_val(32'sd255, 2, "FF");
        // plus sign on the top digit
        add_cfg(C_REG_SYM_HIGH, 64'h2B45_4443_4241_3938);
        add_val(32'sd1, 0, '0);
        // minus sign on digit 3
        add_cfg(C_REG_SYM_HIGH, HEX_HI);
        add_cfg(C_REG_SYM_LOW, 64'h3736_3534_2D32_3130);
        add_val(32'sd1, 0, '0);
        // zero byte on digit 0
        add_cfg(C_REG_SYM_LOW, 64'h3736_3534_3332_3100);
        add_val(32'sd1, 0, '0);
        // digit 2 repeats digit 9
        add_cfg(C_REG_SYM_LOW, 64'h3736_3534_3339_3130);
        add_val(32'sd1, 0, '0);
        // bad bytes only above the radix are ignored
        add_cfg(C_REG_SYM_LOW, HEX_LO);
        add_cfg(C_REG_SYM_HIGH, 64'h0045_2D43_4241_3938);
        add_cfg(C_REG_RADIX, 64'd10);
        add_val(-32'sd255, 4, "-255");
        add_cfg(C_REG_SPARE, 64'hA5A5_5A5A_FFFF_0000);
        add_val(32'sd99, 2, "99");
        add_cfg(C_REG_RADIX, 64'd3);
        add_cfg(C_REG_SYM_LOW, 64'h0000_0000_00FF_807A);
        add_val(32'sd5, -1, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                wait_drained();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                hold = (i + 1 < dir_tab.size()) && !dir_tab[i+1].is_cfg;
                send_value(dir_tab[i].value, dir_tab[i].n_txt, dir_tab[i].txt, hold);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 15 : (ph == 1) ? 47 : 0;
            for (int blk = 0; blk < 8; blk++) begin
                wait_drained();
                new_setting();
                for (int k = 0; k < 19; k++) begin
                    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 300) : 0;
                    hold = (gap == 0) && (k != 18);
                    send_value(pick_value(), -1, '0, hold);
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        while (exp_syms.size() != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);

        $display("Converted %0d requests under %0d register writes, %0d symbols checked.",
                 n_items, n_writes, n_results);
        $display("Settings spanned radix 2..16, invalid radices and broken symbol tables.");
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("%0t: timeout, %0d symbols still expected", $time, exp_syms.size());
        $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sirs_pkg.sv
rtl/core/sirs_check.sv
rtl/core/sirs_divider.sv
rtl/core/sirs_stack.sv
rtl/core/signed_int_to_radix_symbols.sv
rtl/core/sirs_checker.sv
tb/tb_signed_int_to_radix_symbols.sv
